FILE: sv/ps2_mouse_packet_cursor_macros.svh
// Assertion macros for the PS/2 mouse packet cursor block.
// Clocked on aclk, disabled while aresetn is low; define ASSERT_OFF to drop them.
`ifndef PS2_MOUSE_PACKET_CURSOR_MACROS_SVH
`define PS2_MOUSE_PACKET_CURSOR_MACROS_SVH

`ifndef ASSERT_OFF
`define PS2MC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define PS2MC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PS2MC_ASSERT(label, prop, msg)
`define PS2MC_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: sv/ps2mc_pkg.sv
// Shared types and constants for the PS/2 mouse packet cursor block.
// No dependencies.
package ps2mc_pkg;

    localparam int POS_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int SUM_W   = POS_W + 2;   // unsigned position plus signed 9-bit delta, as a signed sum
    localparam int TDATA_W = 32;          // cursor_x, cursor_y, left_pressed, padded

    localparam logic [POS_W-1:0] X_LIMIT_RESET = 12'd1023;
    localparam logic [POS_W-1:0] Y_LIMIT_RESET = 12'd767;
    localparam logic [POS_W-1:0] POS_X_RESET   = 12'd512;
    localparam logic [POS_W-1:0] POS_Y_RESET   = 12'd384;

    // header byte bit positions
    localparam int HDR_LEFT   = 0;
    localparam int HDR_X_SIGN = 4;
    localparam int HDR_Y_SIGN = 5;
    localparam int HDR_X_OVF  = 6;
    localparam int HDR_Y_OVF  = 7;

    typedef enum logic [0:0] {
        CFG_X_LIMIT = 1'b0,
        CFG_Y_LIMIT = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BYTE_HEADER = 2'd0,
        BYTE_DX     = 2'd1,
        BYTE_DY     = 2'd2
    } byte_idx_t;

endpackage

FILE: sv/ps2_mouse_packet_cursor.sv
// PS/2 mouse three-byte packet decoder driving a clamped cursor.
// The third mouse byte passes the input register and then the result register before m_tvalid.
// Throughput: one byte per cycle while no packet end stalls; input register, one decode/update stage, result register.
// A held result does not block input; only a packet end waiting on a full result stalls.
// Reset (aresetn low, synchronous): cursor 512/384, limits 1023/767, button and
// byte counter cleared, both stages emptied.
`include "ps2_mouse_packet_cursor_macros.svh"

module ps2_mouse_packet_cursor (
    input  logic                           aclk,
    input  logic                           aresetn,
    // byte input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ps2mc_pkg::BYTE_W-1:0]   s_tdata,   // [7:0] data_byte
    input  logic                           s_tuser,   // [0] from_mouse
    // cursor result
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ps2mc_pkg::TDATA_W-1:0]  m_tdata,   // [11:0] cursor_x, [23:12] cursor_y,
                                                      // [24] left_pressed, [31:25] zero
    output logic                           m_tuser,   // [0] packet_dropped
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  ps2mc_pkg::cfg_reg_t            cfg_index,
    input  logic [ps2mc_pkg::POS_W-1:0]    cfg_data
);
    import ps2mc_pkg::*;

    logic [POS_W-1:0]  x_limit_reg, y_limit_reg;

    logic              in_valid_reg;
    logic              in_mouse_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    byte_idx_t         byte_idx_reg, byte_idx_next;
    logic [BYTE_W-1:0] header_reg, dx_reg;
    logic [POS_W-1:0]  pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic              left_reg, left_next;

    logic              m_valid_reg;
    logic [POS_W-1:0]  m_x_reg, m_y_reg;
    logic              m_left_reg, m_drop_reg;

    logic              produce, overflow, advance;
    logic [SUM_W-1:0]  sum_x, sum_y;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_X_LIMIT: x_limit_reg <= cfg_data;
                CFG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // decode stage
    assign produce  = in_mouse_reg && (byte_idx_reg != BYTE_HEADER) && (byte_idx_reg != BYTE_DX);
    assign overflow = header_reg[HDR_X_OVF] | header_reg[HDR_Y_OVF];
    assign advance  = in_valid_reg && (!produce || !m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign sum_x = {2'b00, pos_x_reg}
                 + {{(SUM_W-BYTE_W){header_reg[HDR_X_SIGN]}}, dx_reg};
    assign sum_y = {2'b00, pos_y_reg}
                 - {{(SUM_W-BYTE_W){header_reg[HDR_Y_SIGN]}}, in_byte_reg};

    always_comb begin
        byte_idx_next = byte_idx_reg;
        pos_x_next    = pos_x_reg;
        pos_y_next    = pos_y_reg;
        left_next     = left_reg;
        if (in_mouse_reg) begin
            unique case (byte_idx_reg)
                BYTE_HEADER: byte_idx_next = BYTE_DX;
                BYTE_DX:     byte_idx_next = BYTE_DY;
                default: begin
                    byte_idx_next = BYTE_HEADER;
                    if (!overflow) begin
                        left_next = header_reg[HDR_LEFT];
                        // clamp each axis to 0 .. limit
                        if (sum_x[SUM_W-1])
                            pos_x_next = '0;
                        else if (sum_x[SUM_W-2:0] > {1'b0, x_limit_reg})
                            pos_x_next = x_limit_reg;
                        else
                            pos_x_next = sum_x[POS_W-1:0];
                        if (sum_y[SUM_W-1])
                            pos_y_next = '0;
                        else if (sum_y[SUM_W-2:0] > {1'b0, y_limit_reg})
                            pos_y_next = y_limit_reg;
                        else
                            pos_y_next = sum_y[POS_W-1:0];
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            in_mouse_reg <= 1'b0;
            in_byte_reg  <= '0;
            byte_idx_reg <= BYTE_HEADER;
            header_reg   <= '0;
            dx_reg       <= '0;
            pos_x_reg    <= POS_X_RESET;
            pos_y_reg    <= POS_Y_RESET;
            left_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
                in_mouse_reg <= s_tuser;
                in_byte_reg  <= s_tdata;
            end
            if (advance) begin
                byte_idx_reg <= byte_idx_next;
                pos_x_reg    <= pos_x_next;
                pos_y_reg    <= pos_y_next;
                left_reg     <= left_next;
                if (in_mouse_reg && byte_idx_reg == BYTE_HEADER)
                    header_reg <= in_byte_reg;
                if (in_mouse_reg && byte_idx_reg == BYTE_DX)
                    dx_reg <= in_byte_reg;
            end
            if (advance && produce)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // result payload, loaded with the post-packet state
    always_ff @(posedge aclk) begin
        if (advance && produce) begin
            m_x_reg    <= pos_x_next;
            m_y_reg    <= pos_y_next;
            m_left_reg <= left_next;
            m_drop_reg <= overflow;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_W-2*POS_W-1){1'b0}}, m_left_reg, m_y_reg, m_x_reg};
    assign m_tuser  = m_drop_reg;

    `PS2MC_ASSERT(a_result_in_limits, !(m_valid_reg && !m_drop_reg) || ((m_x_reg <= x_limit_reg) && (m_y_reg <= y_limit_reg)), "accepted packet left cursor beyond limit")
    `PS2MC_ASSERT_NEXT(a_drop_holds_cursor, advance && produce && overflow, (pos_x_reg == $past(pos_x_reg)) && (pos_y_reg == $past(pos_y_reg)) && (left_reg == $past(left_reg)), "dropped packet changed cursor state")
    `PS2MC_ASSERT(a_result_from_third_byte, !$rose(m_valid_reg) || $past(advance && produce), "result raised without a completed packet")
    `PS2MC_ASSERT_NEXT(a_packet_wraps_counter, advance && produce, byte_idx_reg == BYTE_HEADER, "byte counter did not wrap after packet end")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for ps2_mouse_packet_cursor: streams mouse and other bytes,
// tracks the cursor in a local model and compares every packet result field by field.
// Depends on ps2mc_pkg and the ps2_mouse_packet_cursor RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ps2mc_pkg::*;

    localparam int PIPE_LATENCY = 2;
    localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct {
        logic [POS_W-1:0] cur_x;
        logic [POS_W-1:0] cur_y;
        logic             left;
        logic             dropped;
    } cursor_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    cfg_reg_t             cfg_index = CFG_X_LIMIT;
    logic [POS_W-1:0]     cfg_data = '0;

    // expected cursor results, oldest first
    cursor_result_t       pending_cursor[$];
    int                   mismatch_count = 0;

    // local copy of the block's state and limits
    byte_idx_t            pkt_phase;
    logic [7:0]           hdr_q;
    logic [7:0]           dx_q;
    logic [POS_W-1:0]     pos_x_q;
    logic [POS_W-1:0]     pos_y_q;
    logic                 left_q;
    logic [POS_W-1:0]     x_bound;
    logic [POS_W-1:0]     y_bound;

    // traffic shaping knobs
    bit                   tx_gaps = 1'b1;
    bit                   rx_stalls = 1'b1;
    bit                   add_noise = 1'b0;
    int                   hold_off_cycles = 0;

    ps2_mouse_packet_cursor dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [POS_W-1:0] clamp_axis(input int v, input logic [POS_W-1:0] bound);
        if (v < 0) return '0;
        if (v > int'(bound)) return bound;
        return v[POS_W-1:0];
    endfunction

    // Advance the packet assembler by one accepted byte; queue a result on a packet end.
    function automatic void advance_cursor(input logic mouse, input logic [7:0] b);
        cursor_result_t r;
        int step_x;
        int step_y;
        if (!mouse) return;
        case (pkt_phase)
            BYTE_HEADER: begin
                hdr_q = b;
                pkt_phase = BYTE_DX;
            end
            BYTE_DX: begin
                dx_q = b;
                pkt_phase = BYTE_DY;
            end
            default: begin
                pkt_phase = BYTE_HEADER;
                r.dropped = hdr_q[HDR_X_OVF] | hdr_q[HDR_Y_OVF];
                if (!r.dropped) begin
                    left_q = hdr_q[HDR_LEFT];
                    step_x = hdr_q[HDR_X_SIGN] ? int'(dx_q) - 256 : int'(dx_q);
                    step_y = hdr_q[HDR_Y_SIGN] ? int'(b) - 256 : int'(b);
                    pos_x_q = clamp_axis(int'(pos_x_q) + step_x, x_bound);
                    pos_y_q = clamp_axis(int'(pos_y_q) - step_y, y_bound);
                end
                r.cur_x = pos_x_q;
                r.cur_y = pos_y_q;
                r.left = left_q;
                pending_cursor.push_back(r);
            end
        endcase
    endfunction

    // Track accepted bytes and register writes.
    always @(posedge aclk) begin
        if (!aresetn) begin
            pkt_phase = BYTE_HEADER;
            hdr_q = '0;
            dx_q = '0;
            pos_x_q = POS_X_RESET;
            pos_y_q = POS_Y_RESET;
            left_q = 1'b0;
            x_bound = X_LIMIT_RESET;
            y_bound = Y_LIMIT_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_X_LIMIT: x_bound = cfg_data;
                    CFG_Y_LIMIT: y_bound = cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) advance_cursor(s_tuser, s_tdata);
        end
    end

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        cursor_result_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cursor.size() == 0) begin
                $error("unexpected result: cursor_x %0d cursor_y %0d left_pressed %0b dropped %0b",
                       m_tdata[11:0], m_tdata[23:12], m_tdata[24], m_tuser);
                mismatch_count++;
            end else begin
                e = pending_cursor.pop_front();
                if (m_tdata[11:0] !== e.cur_x) begin
                    $error("cursor_x: expected %0d, got %0d", e.cur_x, m_tdata[11:0]);
                    mismatch_count++;
                end
                if (m_tdata[23:12] !== e.cur_y) begin
                    $error("cursor_y: expected %0d, got %0d", e.cur_y, m_tdata[23:12]);
                    mismatch_count++;
                end
                if (m_tdata[24] !== e.left) begin
                    $error("left_pressed: expected %0b, got %0b", e.left, m_tdata[24]);
                    mismatch_count++;
                end
                if (m_tuser !== e.dropped) begin
                    $error("packet_dropped: expected %0b, got %0b", e.dropped, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[31:25] !== '0) begin
                    $error("tdata padding: expected 0, got %0h", m_tdata[31:25]);
                    mismatch_count++;
                end
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off when requested.
    initial begin
        int n;
        forever begin
            n = 0;
            if (hold_off_cycles > 0) begin
                n = hold_off_cycles;
                hold_off_cycles = 0;
            end else if (rx_stalls) begin
                n = $urandom_range(0, 6);
            end
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && hold_off_cycles == 0);
        end
    end

    task automatic send_byte(input logic mouse, input logic [7:0] b);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= mouse;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_packet(input logic [7:0] hdr, input logic [7:0] dx,
                               input logic [7:0] dy, input int nbytes = 3);
        logic [7:0] pkt[3];
        pkt[0] = hdr;
        pkt[1] = dx;
        pkt[2] = dy;
        for (int i = 0; i < nbytes; i++) begin
            if (add_noise && $urandom_range(0, 9) == 0) send_byte(1'b0, 8'($urandom));
            send_byte(1'b1, pkt[i]);
        end
    endtask

    task automatic send_random_packet();
        logic [7:0] hdr;
        int nbytes;
        hdr = 8'($urandom);
        // keep most packets free of overflow so the cursor keeps moving
        if ($urandom_range(0, 7) != 0) hdr[HDR_Y_OVF:HDR_X_OVF] = 2'b00;
        // occasionally cut a packet short to knock the framing out of step
        nbytes = ($urandom_range(0, 24) == 0) ? $urandom_range(1, 2) : 3;
        send_packet(hdr, 8'($urandom), 8'($urandom), nbytes);
    endtask

    // Stop offering input, wait for every expected result, then let the pipe empty.
    task automatic settle_results();
        int guard;
        guard = 0;
        s_tvalid <= 1'b0;
        // let the tracker record the last accepted byte before looking at the queue
        @(posedge aclk);
        while (pending_cursor.size() > 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
        if (pending_cursor.size() > 0) begin
            $error("%0d expected results never arrived", pending_cursor.size());
            mismatch_count++;
            pending_cursor.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [POS_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] pick_bound();
        case ($urandom_range(0, 3))
            0: return 12'd1;
            1: return 12'd4095;
            default: return 12'($urandom_range(1, 4095));
        endcase
    endfunction

    task automatic test_packet_fields();
        send_packet(8'h08, 8'h00, 8'h00);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'h00);
        // full positive deltas with left pressed
        send_packet(8'h09, 8'hFF, 8'hFF);
        // most negative deltas, button released
        send_packet(8'h38, 8'h00, 8'h00);
        // X overflow, then Y overflow: drop, keep cursor and button
        send_packet(8'h49, 8'h10, 8'h10);
        send_packet(8'h89, 8'h10, 8'h10);
        // non-mouse bytes inside a packet are skipped
        send_byte(1'b1, 8'h19);
        send_byte(1'b0, 8'h5A);
        send_byte(1'b1, 8'h80);
        send_byte(1'b1, 8'h7F);
        send_packet(8'hFF, 8'hFF, 8'hFF);
        settle_results();
    endtask

    task automatic test_limits();
        write_reg(CFG_X_LIMIT, 12'd4095);
        write_reg(CFG_Y_LIMIT, 12'd4095);
        // drive x to its top and y to zero
        repeat (18) send_packet(8'h08, 8'hFF, 8'hFF);
        settle_results();
        // lower both limits to 1, below the cursor's x; the next packet clamps x
        write_reg(CFG_X_LIMIT, 12'd1);
        write_reg(CFG_Y_LIMIT, 12'd1);
        send_packet(8'h08, 8'h00, 8'h00);
        send_packet(8'h28, 8'h05, 8'hF0);
        settle_results();
        write_reg(CFG_X_LIMIT, 12'd0);
        write_reg(CFG_Y_LIMIT, 12'd0);
        send_packet(8'h28, 8'h40, 8'h80);
        settle_results();
        write_reg(CFG_X_LIMIT, 12'd4095);
        write_reg(CFG_Y_LIMIT, 12'd4095);
        // walk y to its top
        repeat (18) send_packet(8'h28, 8'h01, 8'h00);
        settle_results();
        write_reg(CFG_X_LIMIT, X_LIMIT_RESET);
        write_reg(CFG_Y_LIMIT, Y_LIMIT_RESET);
    endtask

    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_stalls = 1'b1;
        hold_off_cycles = 300;
        repeat (40) send_random_packet();
        settle_results();
        tx_gaps = 1'b1;
    endtask

    task automatic test_sender_pause();
        repeat (10) send_random_packet();
        settle_results();
        repeat (10) send_random_packet();
        settle_results();
    endtask

    task automatic test_random_packets();
        add_noise = 1'b1;
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_X_LIMIT, pick_bound());
            write_reg(CFG_Y_LIMIT, pick_bound());
            tx_gaps = (ph % 3) != 1;
            rx_stalls = (ph % 4) != 2;
            repeat (34) send_random_packet();
            settle_results();
        end
        add_noise = 1'b0;
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_packet_fields();
        test_limits();
        test_backpressure();
        test_sender_pause();
        test_random_packets();
        settle_results();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
